/* rtl/isva_pkg.sv */
package isva_pkg;

    // Longest vector, in byte pairs, that the accumulators are sized for
    localparam longint MAX_BYTES = 65536;

    localparam int PRIMARY_W = 26;
    localparam int NORM_W    = 24;
    localparam int TERM_W    = 10;
    localparam int NTERM_W   = 8;

    // Saturation bounds, each limited to what the accumulator can hold
    localparam longint PRIMARY_FIELD_MAX = (longint'(1) <<< (PRIMARY_W - 1)) - 1;
    localparam longint PRIMARY_FIELD_MIN = -(longint'(1) <<< (PRIMARY_W - 1));
    localparam longint NORM_FIELD_MAX    = (longint'(1) <<< NORM_W) - 1;

    localparam longint DOT_HI_RAW  = 128 * MAX_BYTES;
    localparam longint DOT_LO_RAW  = -112 * MAX_BYTES;
    localparam longint DIST_HI_RAW = 450 * MAX_BYTES;
    localparam longint NORM_HI_RAW = 128 * MAX_BYTES;

    localparam logic signed [PRIMARY_W:0] DOT_HI =
        (PRIMARY_W + 1)'((DOT_HI_RAW < PRIMARY_FIELD_MAX) ? DOT_HI_RAW : PRIMARY_FIELD_MAX);
    localparam logic signed [PRIMARY_W:0] DOT_LO =
        (PRIMARY_W + 1)'((DOT_LO_RAW > PRIMARY_FIELD_MIN) ? DOT_LO_RAW : PRIMARY_FIELD_MIN);
    localparam logic signed [PRIMARY_W:0] DIST_HI =
        (PRIMARY_W + 1)'((DIST_HI_RAW < PRIMARY_FIELD_MAX) ? DIST_HI_RAW : PRIMARY_FIELD_MAX);
    localparam logic [NORM_W:0] NORM_HI =
        (NORM_W + 1)'((NORM_HI_RAW < NORM_FIELD_MAX) ? NORM_HI_RAW : NORM_FIELD_MAX);

    // Metric mode codes; the unused code behaves as the inner product
    typedef enum logic [1:0] {
        MODE_DOT  = 2'd0,
        MODE_DIST = 2'd1,
        MODE_FULL = 2'd2
    } metric_mode_t;

    // Per-item contribution handed from the term unit to the accumulators
    typedef struct packed {
        logic signed [TERM_W-1:0] primary;
        logic [NTERM_W-1:0]       left_sq;
        logic [NTERM_W-1:0]       right_sq;
        logic                     is_dist;
        logic                     is_full;
    } term_t;

endpackage

/* rtl/isva_terms.sv */
module isva_terms
    import isva_pkg::*;
(
    input  logic [7:0] left_byte,
    input  logic [7:0] right_byte,
    input  logic [1:0] mode,
    output term_t      terms
);

    logic signed [3:0] l0;
    logic signed [3:0] l1;
    logic signed [3:0] r0;
    logic signed [3:0] r1;
    logic signed [7:0] p0;
    logic signed [7:0] p1;
    logic signed [4:0] d0;
    logic signed [4:0] d1;
    logic signed [TERM_W-1:0] dsq0;
    logic signed [TERM_W-1:0] dsq1;
    logic signed [7:0] lsq0;
    logic signed [7:0] lsq1;
    logic signed [7:0] rsq0;
    logic signed [7:0] rsq1;
    logic is_dist;
    logic is_full;

    // Split the packed bytes into signed nibbles, low nibble first
    assign l0 = $signed(left_byte[3:0]);
    assign l1 = $signed(left_byte[7:4]);
    assign r0 = $signed(right_byte[3:0]);
    assign r1 = $signed(right_byte[7:4]);

    // Form the element products and differences
    assign p0   = 8'(l0) * 8'(r0);
    assign p1   = 8'(l1) * 8'(r1);
    assign d0   = 5'(l0) - 5'(r0);
    assign d1   = 5'(l1) - 5'(r1);
    assign dsq0 = TERM_W'(d0) * TERM_W'(d0);
    assign dsq1 = TERM_W'(d1) * TERM_W'(d1);
    assign lsq0 = 8'(l0) * 8'(l0);
    assign lsq1 = 8'(l1) * 8'(l1);
    assign rsq0 = 8'(r0) * 8'(r0);
    assign rsq1 = 8'(r1) * 8'(r1);

    // Decode the mode; the spare code falls back to the inner product
    always_comb
    begin
        is_dist = 1'b0;
        is_full = 1'b0;
        unique case (mode)
            MODE_DOT:  ;
            MODE_DIST: is_dist = 1'b1;
            MODE_FULL: is_full = 1'b1;
            default:   ;
        endcase
    end

    // Select the contribution of this item
    always_comb
    begin
        terms.is_dist    = is_dist;
        terms.is_full    = is_full;
        if (is_dist)
            terms.primary = dsq0 + dsq1;
        else
            terms.primary = TERM_W'(p0) + TERM_W'(p1);
        terms.left_sq  = NTERM_W'(lsq0) + NTERM_W'(lsq1);
        terms.right_sq = NTERM_W'(rsq0) + NTERM_W'(rsq1);
    end

endmodule

/* rtl/isva_accum.sv */
module isva_accum
    import isva_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        item_last,
    input  term_t                       terms,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic signed [PRIMARY_W-1:0] primary_sum,
    output logic [NORM_W-1:0]           left_norm_sum,
    output logic [NORM_W-1:0]           right_norm_sum
);

    logic signed [PRIMARY_W-1:0] primary_acc_reg;
    logic signed [PRIMARY_W-1:0] primary_acc_next;
    logic [NORM_W-1:0]           left_acc_reg;
    logic [NORM_W-1:0]           left_acc_next;
    logic [NORM_W-1:0]           right_acc_reg;
    logic [NORM_W-1:0]           right_acc_next;
    logic                        out_valid_reg;
    logic signed [PRIMARY_W-1:0] primary_out_reg;
    logic [NORM_W-1:0]           left_out_reg;
    logic [NORM_W-1:0]           right_out_reg;

    logic signed [PRIMARY_W:0]   primary_raw;
    logic signed [PRIMARY_W:0]   primary_lo;
    logic signed [PRIMARY_W:0]   primary_hi;
    logic signed [PRIMARY_W:0]   primary_sat;
    logic [NORM_W:0]             left_raw;
    logic [NORM_W:0]             right_raw;
    logic [NORM_W-1:0]           left_sat;
    logic [NORM_W-1:0]           right_sat;

    // Add this item's contribution with one guard bit
    assign primary_raw = (PRIMARY_W + 1)'(primary_acc_reg) + (PRIMARY_W + 1)'(terms.primary);
    assign left_raw    = (NORM_W + 1)'(left_acc_reg) + (NORM_W + 1)'(terms.left_sq);
    assign right_raw   = (NORM_W + 1)'(right_acc_reg) + (NORM_W + 1)'(terms.right_sq);

    // Clamp to the bounds of the mode in use
    assign primary_lo = terms.is_dist ? '0 : DOT_LO;
    assign primary_hi = terms.is_dist ? DIST_HI : DOT_HI;

    always_comb
    begin
        priority if (primary_raw < primary_lo)
            primary_sat = primary_lo;
        else if (primary_raw > primary_hi)
            primary_sat = primary_hi;
        else
            primary_sat = primary_raw;
    end

    assign left_sat  = (left_raw > NORM_HI) ? NORM_HI[NORM_W-1:0] : left_raw[NORM_W-1:0];
    assign right_sat = (right_raw > NORM_HI) ? NORM_HI[NORM_W-1:0] : right_raw[NORM_W-1:0];

    // Update accumulators; norms move only in the full mode, all clear on last
    always_comb
    begin
        primary_acc_next = primary_acc_reg;
        left_acc_next    = left_acc_reg;
        right_acc_next   = right_acc_reg;
        if (advance)
        begin
            if (item_last)
            begin
                primary_acc_next = '0;
                left_acc_next    = '0;
                right_acc_next   = '0;
            end
            else
            begin
                primary_acc_next = primary_sat[PRIMARY_W-1:0];
                if (terms.is_full)
                begin
                    left_acc_next  = left_sat;
                    right_acc_next = right_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_acc_reg <= '0;
            left_acc_reg    <= '0;
            right_acc_reg   <= '0;
        end
        else
        begin
            primary_acc_reg <= primary_acc_next;
            left_acc_reg    <= left_acc_next;
            right_acc_reg   <= right_acc_next;
        end
    end

    // Hold the result item until taken; drop it on the taking edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && item_last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_last)
        begin
            primary_out_reg <= primary_sat[PRIMARY_W-1:0];
            left_out_reg    <= terms.is_full ? left_sat : '0;
            right_out_reg   <= terms.is_full ? right_sat : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign primary_sum    = primary_out_reg;
    assign left_norm_sum  = left_out_reg;
    assign right_norm_sum = right_out_reg;

    // A finished vector leaves all accumulators clear
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_last |=> primary_acc_reg == '0 && left_acc_reg == '0
            && right_acc_reg == '0)
        else $error("accumulators not cleared after last item");

    // The primary accumulator never leaves the widest saturation range
    assert property (@(posedge clk) disable iff (!rst_n)
        (PRIMARY_W + 1)'(primary_acc_reg) >= DOT_LO
            && (PRIMARY_W + 1)'(primary_acc_reg) <= DIST_HI)
        else $error("primary accumulator out of range");

    // Norm accumulators stay within their bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (NORM_W + 1)'(left_acc_reg) <= NORM_HI && (NORM_W + 1)'(right_acc_reg) <= NORM_HI)
        else $error("norm accumulator out of range");

    // A new result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_last |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

endmodule

/* rtl/int4_vector_similarity_accumulator.sv */
// int4 vector similarity accumulator: each item carries one packed byte from
// each of two int4 vectors (two signed nibbles, low nibble first). The item is
// registered on entry, its nibble products, squared differences and squares
// are formed from that register and added into saturating accumulators, and on
// the item marked last the sums go to an output register and the
// accumulators clear. One item is accepted every cycle unless a last item is
// stalled; a last item's sums go to the output register as it leaves the
// input register. Items that are not last keep flowing while a result
// waits; only a last item stalls behind an untaken result.
// metric_mode (cfg_we/cfg_data) selects inner product (0), squared distance
// (1) or dot product with both norms (2); write it only while idle.
module int4_vector_similarity_accumulator
    import isva_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  left_byte,
    input  logic [7:0]                  right_byte,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [PRIMARY_W-1:0] primary_sum,
    output logic [NORM_W-1:0]           left_norm_sum,
    output logic [NORM_W-1:0]           right_norm_sum
);

    logic [1:0] mode_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_left_reg;
    logic [7:0] s1_right_reg;
    logic       s1_last_reg;
    logic [1:0] s1_mode_reg;
    logic       advance;
    logic       in_take;
    term_t      terms;

    // Hold the metric mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_DOT;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    // Advance the input stage unless a last item meets a waiting result
    assign advance       = s1_valid_reg && !(s1_last_reg && out_valid && out_stall);
    assign in_stall      = s1_valid_reg && !advance;
    assign in_take       = in_valid && !in_stall;
    assign s1_valid_next = in_take || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Capture the item with the mode in force on arrival
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_left_reg  <= left_byte;
            s1_right_reg <= right_byte;
            s1_last_reg  <= last;
            s1_mode_reg  <= mode_reg;
        end
    end

    isva_terms u_terms (
        .left_byte  (s1_left_reg),
        .right_byte (s1_right_reg),
        .mode       (s1_mode_reg),
        .terms      (terms)
    );

    isva_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .item_last      (s1_last_reg),
        .terms          (terms),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .primary_sum    (primary_sum),
        .left_norm_sum  (left_norm_sum),
        .right_norm_sum (right_norm_sum)
    );

endmodule
